@@ sv/btmx_pkg.sv @@
// Package for the binary trie max-xor block: sizes, node entry layout, controller states.
// Depends on nothing; binary_trie_max_xor.sv takes everything it needs from here.
package btmx_pkg;

   localparam int KEY_BITS   = 51;
   localparam int NODE_COUNT = 65536;

   localparam int NODE_W = $clog2(NODE_COUNT);   // node index
   localparam int USED_W = NODE_W + 1;           // allocation count, holds NODE_COUNT itself
   localparam int LVL_W  = $clog2(KEY_BITS + 1); // levels still to walk, KEY_BITS down to 0
   localparam int BIT_W  = $clog2(KEY_BITS);     // bit position within a key
   localparam int SUM_W  = USED_W + 1;           // pool fill check

   // One pool entry: both child links of a node, 0 meaning no child.
   typedef struct packed {
      logic [NODE_W-1:0] right;
      logic [NODE_W-1:0] left;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_WRITE,
      ST_DONE
   } state_type;

endpackage

@@ sv/binary_trie_max_xor.sv @@
// Top level of the binary trie max-xor block: node pool memory, walk controller, result register.
// Depends on btmx_pkg for sizes, the node entry type and the controller states.
//
//   channel | direction | ports                         | beat
//   --------+-----------+-------------------------------+------------------------------------
//   req     | in        | req_valid/ready, cmd, key     | one insert or query
//   rsp     | out       | rsp_valid/ready, best_xor,    | one result for each request beat
//           |           | status                        |
//
// A query walks one trie level per cycle behind the pool's read. An insert walks the existing
// nodes, finds the missing child, then does the link writes plus the leaf write; a duplicate
// or dropped insert ends after the walk.
// Reset: no clearing pass; new nodes are written whole and the root reads as empty until its
// first write. Stalls: a finished result waits in the done state until the output register is
// free; the next request beat is taken once the controller is back at idle.
module binary_trie_max_xor (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_cmd,
   input  logic [btmx_pkg::KEY_BITS-1:0] req_key,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [btmx_pkg::KEY_BITS-1:0] rsp_best_xor,
   output logic                         rsp_status
);

   localparam int NODE_W = btmx_pkg::NODE_W;
   localparam int USED_W = btmx_pkg::USED_W;
   localparam int LVL_W  = btmx_pkg::LVL_W;
   localparam int BIT_W  = btmx_pkg::BIT_W;
   localparam int SUM_W  = btmx_pkg::SUM_W;
   localparam int KB     = btmx_pkg::KEY_BITS;

   // Node pool: both child links of one node per entry, read data registered.
   btmx_pkg::entry_type mem [btmx_pkg::NODE_COUNT];
   btmx_pkg::entry_type mem_rd_ff;

   btmx_pkg::state_type state_ff, state_in;

   logic                cmd_ff, cmd_in;
   logic [KB-1:0]       key_ff, key_in;
   logic [KB-1:0]       acc_ff, acc_in;
   logic [LVL_W-1:0]    lvl_ff, lvl_in;
   logic [NODE_W-1:0]   node_ff, node_in;
   logic [USED_W-1:0]   used_ff, used_in;
   logic                status_ff, status_in;
   logic                root_wr_ff, root_wr_in;
   logic                rd_zero_ff, rd_zero_in;
   btmx_pkg::entry_type keep_ff, keep_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [KB-1:0]       rsp_best_ff, rsp_best_in;
   logic                rsp_status_ff, rsp_status_in;

   // memory port controls
   logic                rd_en;
   logic [NODE_W-1:0]   rd_addr;
   logic                wr_en;
   logic [NODE_W-1:0]   wr_addr;
   btmx_pkg::entry_type wr_data;

   // walk datapath
   btmx_pkg::entry_type entry;
   logic [BIT_W-1:0]    bit_idx;
   logic                kbit;
   logic [NODE_W-1:0]   want;
   logic [NODE_W-1:0]   other;
   logic [NODE_W-1:0]   nx;
   logic                last_lvl;
   logic [SUM_W-1:0]    need_sum;
   logic                pool_full;
   logic                rsp_free;

   assign req_ready    = (state_ff == btmx_pkg::ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_best_xor = rsp_best_ff;
   assign rsp_status   = rsp_status_ff;

   // Root entry reads as empty until the first insert writes it.
   assign entry    = rd_zero_ff ? '0 : mem_rd_ff;
   assign bit_idx  = BIT_W'(lvl_ff - LVL_W'(1));
   assign kbit     = key_ff[bit_idx];
   assign want     = kbit ? entry.left : entry.right;
   assign other    = kbit ? entry.right : entry.left;
   assign nx       = kbit ? entry.right : entry.left;
   assign last_lvl = (lvl_ff == LVL_W'(1));
   assign need_sum = SUM_W'(used_ff) + SUM_W'(lvl_ff);
   assign pool_full = (need_sum > SUM_W'(btmx_pkg::NODE_COUNT));
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         btmx_pkg::ST_IDLE: begin
            if (req_valid) state_in = btmx_pkg::ST_WALK;
         end
         btmx_pkg::ST_WALK: begin
            if (cmd_ff) begin
               if (last_lvl) state_in = btmx_pkg::ST_DONE;
            end else if (nx != '0) begin
               if (last_lvl) state_in = btmx_pkg::ST_DONE;
            end else if (pool_full) begin
               state_in = btmx_pkg::ST_DONE;
            end else begin
               state_in = btmx_pkg::ST_WRITE;
            end
         end
         btmx_pkg::ST_WRITE: begin
            if (lvl_ff == '0) state_in = btmx_pkg::ST_DONE;
         end
         btmx_pkg::ST_DONE: begin
            if (rsp_free) state_in = btmx_pkg::ST_IDLE;
         end
         default: state_in = btmx_pkg::ST_IDLE;
      endcase
   end

   // Datapath, memory port controls and result register.
   always_comb begin
      btmx_pkg::entry_type base;
      base          = keep_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      acc_in        = acc_ff;
      lvl_in        = lvl_ff;
      node_in       = node_ff;
      used_in       = used_ff;
      status_in     = status_ff;
      root_wr_in    = root_wr_ff;
      keep_in       = keep_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = node_ff;
      wr_data       = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_best_in   = rsp_best_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         btmx_pkg::ST_IDLE: begin
            // Latch the request and start reading the root.
            if (req_valid) begin
               cmd_in    = req_cmd;
               key_in    = req_key;
               acc_in    = '0;
               lvl_in    = LVL_W'(KB);
               node_in   = '0;
               status_in = 1'b0;
               rd_en     = 1'b1;
               rd_addr   = '0;
            end
         end
         btmx_pkg::ST_WALK: begin
            lvl_in = lvl_ff - LVL_W'(1);
            if (cmd_ff) begin
               // Prefer the child opposite to the key bit; stay put if both are missing.
               acc_in = {acc_ff[KB-2:0], (want != '0)};
               if (want != '0) begin
                  node_in = want;
               end else if (other != '0) begin
                  node_in = other;
               end
               rd_en   = !last_lvl;
               rd_addr = node_in;
            end else if (nx != '0) begin
               // Follow the existing path.
               node_in = nx;
               rd_en   = !last_lvl;
               rd_addr = nx;
            end else begin
               // Path ends here: drop the insert or keep the parent entry for the first write.
               lvl_in    = lvl_ff;
               status_in = pool_full;
               keep_in   = entry;
            end
         end
         btmx_pkg::ST_WRITE: begin
            // Link the next fresh node below this one; the last node is written as a leaf.
            if (lvl_ff != '0) begin
               if (kbit) begin
                  base.right = used_ff[NODE_W-1:0];
               end else begin
                  base.left = used_ff[NODE_W-1:0];
               end
               node_in = used_ff[NODE_W-1:0];
               used_in = used_ff + USED_W'(1);
               lvl_in  = lvl_ff - LVL_W'(1);
            end
            wr_en   = 1'b1;
            wr_addr = node_ff;
            wr_data = base;
            keep_in = '0;
            if (node_ff == '0) root_wr_in = 1'b1;
         end
         btmx_pkg::ST_DONE: begin
            // Hand the result over once the output register is free.
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_best_in   = acc_ff;
               rsp_status_in = status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rd_zero_in = (rd_addr == '0) && !root_wr_ff;

   // Node pool: writes and reads never fall in the same cycle.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) begin
         mem_rd_ff  <= mem[rd_addr];
         rd_zero_ff <= rd_zero_in;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= btmx_pkg::ST_IDLE;
         used_ff      <= USED_W'(1);
         root_wr_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         root_wr_ff   <= root_wr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      acc_ff        <= acc_in;
      lvl_ff        <= lvl_in;
      node_ff       <= node_in;
      status_ff     <= status_in;
      keep_ff       <= keep_in;
      rsp_best_ff   <= rsp_best_in;
      rsp_status_ff <= rsp_status_in;
   end

`ifndef SYNTHESIS
   // The allocation count never passes the pool size.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(btmx_pkg::NODE_COUNT))
      else $error("node pool count overflow");

   // Every write lands on an allocated node.
   a_write_alloc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == btmx_pkg::ST_WRITE) |-> (SUM_W'(node_ff) < SUM_W'(used_ff)))
      else $error("write to an unallocated node");

   // A dropped insert leaves the pool count as it was.
   a_drop_keeps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == btmx_pkg::ST_WALK && !cmd_ff && nx == '0 && pool_full) |=>
      $stable(used_ff))
      else $error("dropped insert changed the pool");

   // A result with the drop flag never carries a xor value.
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_best_xor == '0))
      else $error("dropped insert reports a xor value");
`endif

endmodule

@@ tb/sv/binary_trie_max_xor_tb.sv @@
// Self-checking bench for binary_trie_max_xor: directed beats, random traffic, long hold-off.
// Depends on btmx_pkg (key width, pool size, index width) and the binary_trie_max_xor RTL.
module binary_trie_max_xor_tb;

   localparam int KB = btmx_pkg::KEY_BITS;
   localparam int NW = btmx_pkg::NODE_W;
   localparam int unsigned POOL = btmx_pkg::NODE_COUNT;

   typedef logic [KB-1:0] key_type;

   // Request and status codes as the block defines them.
   localparam logic CMD_INSERT  = 1'b0;
   localparam logic CMD_QUERY   = 1'b1;
   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   localparam key_type KEY_ONES = '1;
   localparam key_type KEY_TOP  = key_type'(1) << (KB - 1);
   localparam key_type KEY_ALT5 = 51'h5_5555_5555_5555;
   localparam key_type KEY_ALTA = 51'h2_AAAA_AAAA_AAAA;

   localparam int IDLE_LIMIT = 2000;   // cycles with no beat on either side
   localparam int LONG_HOLD  = 300;    // receiver hold-off that backs the block up
   localparam int TAIL_WAIT  = 60;     // a full walk plus margin after the last result

   typedef struct {
      logic    cmd;
      key_type key;
      key_type best;
      logic    status;
   } answer_type;

   typedef struct {
      logic    cmd;
      key_type key;
      bit      typed;      // expected result written in the row itself
      key_type best;
      logic    status;
   } probe_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   logic    req_cmd;
   key_type req_key;
   logic    rsp_valid;
   logic    rsp_ready;
   key_type rsp_best_xor;
   logic    rsp_status;

   // Shadow trie: same allocation order as the block, so node indexes line up.
   logic [NW-1:0] trie_left  [POOL];
   logic [NW-1:0] trie_right [POOL];
   int unsigned   trie_used;
   key_type       stored_keys[$];

   answer_type pending_answers[$];
   int         fail_count = 0;
   int         idle_cycles = 0;

   // Side info handed from the sender to the monitor with each request beat.
   bit      row_typed  = 1'b0;
   key_type row_best   = '0;
   logic    row_status = STATUS_DONE;

   bit quiet     = 1'b0;   // no gaps on either side while set
   bit hold_long = 1'b0;   // ask the receiver for one long hold-off

   // Directed beats: empty trie, extremes, duplicates, then patterns the predictor checks.
   probe_row_type dir_rows [18] = '{
      '{CMD_QUERY,  '0,       1'b1, '0,       STATUS_DONE},
      '{CMD_QUERY,  KEY_ONES, 1'b1, '0,       STATUS_DONE},
      '{CMD_INSERT, '0,       1'b1, '0,       STATUS_DONE},
      '{CMD_QUERY,  '0,       1'b1, '0,       STATUS_DONE},
      '{CMD_QUERY,  KEY_ONES, 1'b1, KEY_ONES, STATUS_DONE},
      '{CMD_INSERT, KEY_ONES, 1'b1, '0,       STATUS_DONE},
      '{CMD_QUERY,  '0,       1'b1, KEY_ONES, STATUS_DONE},
      '{CMD_QUERY,  KEY_ONES, 1'b1, KEY_ONES, STATUS_DONE},
      '{CMD_INSERT, '0,       1'b1, '0,       STATUS_DONE},
      '{CMD_INSERT, KEY_ONES, 1'b1, '0,       STATUS_DONE},
      '{CMD_INSERT, KEY_TOP,  1'b1, '0,       STATUS_DONE},
      '{CMD_QUERY,  KEY_TOP,  1'b0, '0,       STATUS_DONE},
      '{CMD_INSERT, key_type'(1), 1'b1, '0,   STATUS_DONE},
      '{CMD_QUERY,  KEY_ALT5, 1'b0, '0,       STATUS_DONE},
      '{CMD_QUERY,  KEY_ALTA, 1'b0, '0,       STATUS_DONE},
      '{CMD_INSERT, KEY_ALT5, 1'b1, '0,       STATUS_DONE},
      '{CMD_QUERY,  KEY_ALTA, 1'b1, KEY_ONES, STATUS_DONE},
      '{CMD_QUERY,  key_type'(1), 1'b0, '0,   STATUS_DONE}
   };

   binary_trie_max_xor uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_key      (req_key),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_best_xor (rsp_best_xor),
      .rsp_status   (rsp_status)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Count the nodes an insert of k would add to the shadow trie.
   function automatic int nodes_needed(key_type k);
      logic [NW-1:0] node;
      logic [NW-1:0] nx;
      int            i;
      node = '0;
      i = KB - 1;
      while (i >= 0) begin
         nx = k[i] ? trie_right[node] : trie_left[node];
         if (nx == '0) break;
         node = nx;
         i--;
      end
      return i + 1;
   endfunction

   // Apply one request to the shadow trie and work out the block's answer.
   function automatic void trie_step(input logic c, input key_type k,
                                     output key_type best, output logic st);
      int unsigned   need;
      logic [NW-1:0] node;
      logic [NW-1:0] nx;
      logic [NW-1:0] want;
      logic [NW-1:0] other;
      best = '0;
      st   = STATUS_DONE;
      node = '0;
      if (c == CMD_INSERT) begin
         need = nodes_needed(k);
         // All or nothing: a path that does not fit leaves the trie untouched.
         if (trie_used + need > POOL) begin
            st = STATUS_FULL;
         end else if (need != 0) begin
            for (int i = KB - 1; i >= 0; i--) begin
               nx = k[i] ? trie_right[node] : trie_left[node];
               if (nx == '0) begin
                  nx = NW'(trie_used);
                  trie_used++;
                  if (k[i]) trie_right[node] = nx;
                  else trie_left[node] = nx;
               end
               node = nx;
            end
            stored_keys.push_back(k);
         end
      end else if (trie_used > 1) begin
         // Prefer the branch opposite the key bit; that sets the answer bit.
         for (int i = KB - 1; i >= 0; i--) begin
            want  = k[i] ? trie_left[node]  : trie_right[node];
            other = k[i] ? trie_right[node] : trie_left[node];
            best  = {best[KB-2:0], want != '0};
            if (want != '0) node = want;
            else if (other != '0) node = other;
         end
      end
   endfunction

   function automatic void flag_failure(string what);
      if (fail_count < 10) $display("%s", what);
      fail_count++;
   endfunction

   function automatic key_type random_key();
      return key_type'({$urandom, $urandom});
   endfunction

   // Keys that land near stored paths, so queries and inserts walk deep.
   function automatic key_type mixed_key();
      key_type r;
      key_type s;
      r = random_key();
      s = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      case ($urandom_range(0, 6))
         0, 1: return r;
         2: return s ^ (key_type'(1) << $urandom_range(0, KB - 1));
         3: return s ^ (r & ((key_type'(1) << $urandom_range(1, 16)) - 1));
         4: return s;
         5: return key_type'($urandom_range(0, 255));
         default: return ~key_type'($urandom_range(0, 255));
      endcase
   endfunction

   // Mostly short gaps, some medium, a few long; none while quiet.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet) return 0;
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 120);
   endfunction

   // Offer one request beat; entered and left at a falling edge.
   task automatic send_beat(input logic c, input key_type k, input bit typed = 1'b0,
                            input key_type best = '0, input logic st = STATUS_DONE);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_cmd    <= c;
      req_key    <= k;
      row_typed  = typed;
      row_best   = best;
      row_status = st;
      // Hold the beat until the block takes it.
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Receiver: random stalls, one long hold-off on request.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         stall = pick_gap();
         if (hold_long) begin
            stall = LONG_HOLD;
            hold_long = 1'b0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(negedge clock);
      end
   end

   // Monitor: check result beats against the oldest expectation, then predict new requests.
   always @(posedge clock) begin
      answer_type exp_ans;
      key_type    pred_best;
      logic       pred_status;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_answers.size() == 0) begin
               flag_failure($sformatf("result beat with nothing pending: best_xor %h status %0d",
                                      rsp_best_xor, rsp_status));
            end else begin
               exp_ans = pending_answers.pop_front();
               if (rsp_best_xor !== exp_ans.best)
                  flag_failure($sformatf("best_xor mismatch cmd %0d key %h: expected %h got %h",
                                         exp_ans.cmd, exp_ans.key, exp_ans.best,
                                         rsp_best_xor));
               if (rsp_status !== exp_ans.status)
                  flag_failure($sformatf("status mismatch cmd %0d key %h: expected %0d got %0d",
                                         exp_ans.cmd, exp_ans.key, exp_ans.status,
                                         rsp_status));
            end
         end
         if (req_valid && req_ready) begin
            // Advance the shadow trie on every beat, even where the row types the answer.
            trie_step(req_cmd, req_key, pred_best, pred_status);
            if (row_typed) begin
               pred_best   = row_best;
               pred_status = row_status;
            end
            pending_answers.push_back(answer_type'{req_cmd, req_key, pred_best, pred_status});
         end
      end
   end

   // Watchdog: end the run when no beat moves for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_cmd   = CMD_INSERT;
      req_key   = '0;
      for (int i = 0; i < POOL; i++) begin
         trie_left[i]  = '0;
         trie_right[i] = '0;
      end
      trie_used = 1;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table.
      foreach (dir_rows[i])
         send_beat(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].typed,
                   dir_rows[i].best, dir_rows[i].status);

      // Random traffic; one long receiver hold-off and one stretch with no gaps.
      for (int i = 0; i < 700; i++) begin
         if (i == 300) hold_long = 1'b1;
         quiet = (i >= 420 && i < 480);
         send_beat(($urandom_range(0, 99) < 45) ? CMD_INSERT : CMD_QUERY, mixed_key());
      end
      quiet = 1'b0;

      req_valid <= 1'b0;

      // Drain, then watch a little longer for stray result beats.
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);

      if (fail_count == 0 && pending_answers.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/btmx_pkg.sv
sv/binary_trie_max_xor.sv
tb/sv/binary_trie_max_xor_tb.sv
